FILE: sv/pvs_pkg.sv
// Shared constants, types and rounding helpers for the Phong vertex shader.
`default_nettype none
package pvs_pkg;

  localparam int COORD_W_DEF = 20;
  localparam int ADDR_W      = 6;
  localparam int APB_DW      = 64;
  localparam int POS_W       = 60;
  localparam int UNIT_W      = 16;   // signed Q2.14 vector component
  localparam int COS_W       = 15;   // clamped cosine, 0..16384
  localparam int SQRT_STEPS  = 31;   // root bits of a 62-bit sum of squares
  localparam int DIV_STEPS   = 15;   // quotient bits of one unit component
  localparam int NORM_LAT    = 3 + SQRT_STEPS + 1 + DIV_STEPS;
  localparam int POW_STEPS   = 255;

  localparam logic [COS_W-1:0] UNIT_ONE = 15'd16384;

  localparam logic [2:0] REG_MODE      = 3'd0;
  localparam logic [2:0] REG_AMBIENT   = 3'd1;
  localparam logic [2:0] REG_DIFFUSE   = 3'd2;
  localparam logic [2:0] REG_SPECULAR  = 3'd3;
  localparam logic [2:0] REG_SHININESS = 3'd4;
  localparam logic [2:0] REG_LIGHT_POS = 3'd5;
  localparam logic [2:0] REG_EYE_POS   = 3'd6;

  localparam logic [15:0] AMBIENT_RST   = 16'd0;
  localparam logic [15:0] DIFFUSE_RST   = 16'd16384;
  localparam logic [15:0] SPECULAR_RST  = 16'd0;
  localparam logic [7:0]  SHININESS_RST = 8'd16;

  typedef struct packed {
    logic [2:0][29:0] sm;
    logic [2:0]       neg;
    logic             zero;
  } nrm_side_t;

  typedef struct packed {
    logic [2:0][46:0] rem;
    logic [2:0][14:0] q;
    logic [31:0]      den;
    logic [2:0]       neg;
    logic             zero;
  } nrm_div_t;

  // Q28 -> Q14, halves away from zero
  function automatic logic signed [63:0] rnd14(input logic signed [63:0] x);
    logic [63:0] m;
    m = '0;
    if (x >= 0) begin
      rnd14 = (x + 64'sd8192) >>> 14;
    end else begin
      m = -x;
      rnd14 = -$signed((m + 64'd8192) >> 14);
    end
  endfunction

  function automatic logic [COS_W-1:0] clamp_cos(input logic signed [63:0] c);
    if (c < 0) begin
      clamp_cos = '0;
    end else if (c > 64'sd16384) begin
      clamp_cos = UNIT_ONE;
    end else begin
      clamp_cos = c[COS_W-1:0];
    end
  endfunction

endpackage
`default_nettype wire

FILE: sv/phong_vertex_shader.sv
// Phong / Blinn-Phong vertex shader top level: config regs, pipeline, output skid.
//
//  port group   dir  handshake           payload
//  vertex in    in   valid_i / stall_o   src_*_i, pos_*_i, nrm_*_i
//  color out    out  valid_o / stall_i   out_*_o, degenerate_o
//  config       in   psel/penable/pwrite paddr, pwdata, prdata
//
// One vertex per clock while the output skid is empty; the path runs through two
// normalizers (prescale, 31-step sqrt, 15-step divide) and the 255-stage power chain.
// Reset clears valid bits and loads config registers with reset values; no clearing pass.
// The whole pipeline holds only while the one-word output skid is full,
// so stall_o is a register and never depends on stall_i combinationally.
`default_nettype none
module phong_vertex_shader #(
  parameter int COORD_WIDTH = pvs_pkg::COORD_W_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pvs_pkg::ADDR_W-1:0]        paddr,
  input  logic [pvs_pkg::APB_DW-1:0]        pwdata,
  output logic [pvs_pkg::APB_DW-1:0]        prdata,
  output logic                              pready,
  input  logic                              valid_i,
  output logic                              stall_o,
  input  logic [7:0]                        src_red_i,
  input  logic [7:0]                        src_green_i,
  input  logic [7:0]                        src_blue_i,
  input  logic signed [COORD_WIDTH-1:0]     pos_x_i,
  input  logic signed [COORD_WIDTH-1:0]     pos_y_i,
  input  logic signed [COORD_WIDTH-1:0]     pos_z_i,
  input  logic signed [15:0]                nrm_x_i,
  input  logic signed [15:0]                nrm_y_i,
  input  logic signed [15:0]                nrm_z_i,
  output logic                              valid_o,
  input  logic                              stall_i,
  output logic [7:0]                        out_red_o,
  output logic [7:0]                        out_green_o,
  output logic [7:0]                        out_blue_o,
  output logic                              degenerate_o
);
  import pvs_pkg::*;

  localparam int CW = COORD_WIDTH;

  typedef struct packed {
    logic                   ok;
    logic [2:0][7:0]        col;
    logic signed [17:0]     nl;
    logic [2:0][15:0]       n;
    logic [2:0][15:0]       l;
    logic [2:0][15:0]       v;
  } p1_t;

  typedef struct packed {
    logic                   ok;
    logic                   okh;
    logic [2:0][7:0]        col;
    logic signed [17:0]     nl;
    logic [2:0][15:0]       n;
    logic [2:0][15:0]       v;
    logic [2:0][15:0]       h;
    logic [2:0][18:0]       r;
  } q1_t;

  typedef struct packed {
    logic                   ok;
    logic [COS_W-1:0]       cosd;
    logic [2:0][7:0]        col;
  } q2_t;

  typedef struct packed {
    logic                   ok;
    logic [2:0][7:0]        col;
    logic [30:0]            i1;
    logic [38:0]            i2;
  } f1_t;

  typedef struct packed {
    logic [2:0][7:0]        col;
    logic                   dgn;
  } res_t;

  // ---------------- configuration ----------------
  logic              mode_q;
  logic [15:0]       ka_q, kd_q, ks_q;
  logic [7:0]        shin_q;
  logic [POS_W-1:0]  light_q, eye_q;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      ka_q    <= AMBIENT_RST;
      kd_q    <= DIFFUSE_RST;
      ks_q    <= SPECULAR_RST;
      shin_q  <= SHININESS_RST;
      light_q <= '0;
      eye_q   <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[5:3])
        REG_MODE:      mode_q  <= pwdata[0];
        REG_AMBIENT:   ka_q    <= pwdata[15:0];
        REG_DIFFUSE:   kd_q    <= pwdata[15:0];
        REG_SPECULAR:  ks_q    <= pwdata[15:0];
        REG_SHININESS: shin_q  <= pwdata[7:0];
        REG_LIGHT_POS: light_q <= pwdata[POS_W-1:0];
        REG_EYE_POS:   eye_q   <= pwdata[POS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[5:3])
      REG_MODE:      prdata = APB_DW'(mode_q);
      REG_AMBIENT:   prdata = APB_DW'(ka_q);
      REG_DIFFUSE:   prdata = APB_DW'(kd_q);
      REG_SPECULAR:  prdata = APB_DW'(ks_q);
      REG_SHININESS: prdata = APB_DW'(shin_q);
      REG_LIGHT_POS: prdata = APB_DW'(light_q);
      REG_EYE_POS:   prdata = APB_DW'(eye_q);
      default:       prdata = '0;
    endcase
  end

  // ---------------- flow control ----------------
  logic en;
  logic skid_vld_q, out_vld_q;
  res_t skid_q, out_q, res_d;

  assign en      = !skid_vld_q;
  assign stall_o = skid_vld_q;

  // ---------------- stage 0: difference vectors ----------------
  logic                   v0_q;
  logic [2:0][7:0]        col0_q;
  logic [2:0][CW:0]       dl_d, dv_d, dl_q, dv_q;
  logic [2:0][15:0]       dn_q;

  always_comb begin
    logic [63:0]          lsh, esh;
    logic [2:0][CW-1:0]   pos;
    lsh    = '0;
    esh    = '0;
    pos[0] = pos_x_i;
    pos[1] = pos_y_i;
    pos[2] = pos_z_i;
    for (int k = 0; k < 3; k++) begin
      // fields at or past bit 64 shift out to zero
      lsh     = {4'd0, light_q} >> (k * CW);
      esh     = {4'd0, eye_q} >> (k * CW);
      dl_d[k] = {lsh[CW-1], lsh[CW-1:0]} - {pos[k][CW-1], pos[k]};
      dv_d[k] = {esh[CW-1], esh[CW-1:0]} - {pos[k][CW-1], pos[k]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      col0_q <= {src_blue_i, src_green_i, src_red_i};
      dl_q   <= dl_d;
      dv_q   <= dv_d;
      dn_q   <= {nrm_z_i, nrm_y_i, nrm_x_i};
    end
  end

  // ---------------- unit L, V, N ----------------
  logic [2:0][15:0] lu, vu, nu;
  logic             okl, okv, okn;
  logic             vld1;
  logic [2:0][7:0]  col1;

  pvs_norm #(.DW(CW + 1)) u_norm_l (
    .clk_i(clk_i), .en_i(en), .d_i(dl_q), .u_o(lu), .ok_o(okl)
  );
  pvs_norm #(.DW(CW + 1)) u_norm_v (
    .clk_i(clk_i), .en_i(en), .d_i(dv_q), .u_o(vu), .ok_o(okv)
  );
  pvs_norm #(.DW(16)) u_norm_n (
    .clk_i(clk_i), .en_i(en), .d_i(dn_q), .u_o(nu), .ok_o(okn)
  );
  pvs_delay #(.W(24), .DEPTH(NORM_LAT)) u_dly_norm (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en),
    .vld_i(v0_q), .d_i(col0_q), .vld_o(vld1), .d_o(col1)
  );

  // ---------------- P1: N.L and V+L ----------------
  logic             p1_vld_q;
  p1_t              p1_d, p1_q;
  logic [2:0][16:0] hs_d, hs_q;

  always_comb begin
    logic signed [31:0] pr [3];
    logic signed [33:0] s;
    for (int i = 0; i < 3; i++) begin
      pr[i]   = $signed(nu[i]) * $signed(lu[i]);
      hs_d[i] = 17'($signed(vu[i])) + 17'($signed(lu[i]));
    end
    s       = 34'(pr[0]) + 34'(pr[1]) + 34'(pr[2]);
    p1_d.ok  = okl && okv && okn;
    p1_d.col = col1;
    p1_d.nl  = 18'(rnd14(64'(s)));
    p1_d.n   = nu;
    p1_d.l   = lu;
    p1_d.v   = vu;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
    end else if (en) begin
      p1_vld_q <= vld1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q <= p1_d;
      hs_q <= hs_d;
    end
  end

  // ---------------- unit H ----------------
  logic [2:0][15:0] hu;
  logic             okh;
  logic             vld2;
  p1_t              p2;

  pvs_norm #(.DW(17)) u_norm_h (
    .clk_i(clk_i), .en_i(en), .d_i(hs_q), .u_o(hu), .ok_o(okh)
  );
  pvs_delay #(.W($bits(p1_t)), .DEPTH(NORM_LAT)) u_dly_half (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en),
    .vld_i(p1_vld_q), .d_i(p1_q), .vld_o(vld2), .d_o(p2)
  );

  // ---------------- Q1: reflection vector ----------------
  logic q1_vld_q;
  q1_t  q1_d, q1_q;

  always_comb begin
    logic signed [33:0] rp;
    rp = '0;
    for (int i = 0; i < 3; i++) begin
      rp         = $signed(p2.nl) * $signed(p2.n[i]);
      q1_d.r[i]  = 19'(rnd14(64'(rp) <<< 1) - 64'($signed(p2.l[i])));
    end
    q1_d.ok  = p2.ok;
    q1_d.okh = okh;
    q1_d.col = p2.col;
    q1_d.nl  = p2.nl;
    q1_d.n   = p2.n;
    q1_d.v   = p2.v;
    q1_d.h   = hu;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q1_vld_q <= 1'b0;
    end else if (en) begin
      q1_vld_q <= vld2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      q1_q <= q1_d;
    end
  end

  // ---------------- Q2: cosines ----------------
  logic             q2_vld_q;
  q2_t              q2_d, q2_q;
  logic [COS_W-1:0] coss_d, coss_q;

  always_comb begin
    logic signed [34:0] prv [3];
    logic signed [31:0] phn [3];
    logic signed [36:0] srv;
    logic signed [33:0] shn;
    for (int i = 0; i < 3; i++) begin
      prv[i] = $signed(q1_q.r[i]) * $signed(q1_q.v[i]);
      phn[i] = $signed(q1_q.h[i]) * $signed(q1_q.n[i]);
    end
    srv = 37'(prv[0]) + 37'(prv[1]) + 37'(prv[2]);
    shn = 34'(phn[0]) + 34'(phn[1]) + 34'(phn[2]);
    coss_d    = mode_q ? clamp_cos(rnd14(64'(shn))) : clamp_cos(rnd14(64'(srv)));
    q2_d.ok   = q1_q.ok && (!mode_q || q1_q.okh);
    q2_d.cosd = clamp_cos(64'(q1_q.nl));
    q2_d.col  = q1_q.col;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q2_vld_q <= 1'b0;
    end else if (en) begin
      q2_vld_q <= q1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      q2_q   <= q2_d;
      coss_q <= coss_d;
    end
  end

  // ---------------- specular power ----------------
  logic [COS_W-1:0] pw;
  logic             vld3;
  q2_t              q3;

  pvs_pow u_pow (
    .clk_i(clk_i), .en_i(en), .cos_i(coss_q), .exp_i(shin_q), .pow_o(pw)
  );
  pvs_delay #(.W($bits(q2_t)), .DEPTH(POW_STEPS)) u_dly_pow (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en),
    .vld_i(q2_vld_q), .d_i(q2_q), .vld_o(vld3), .d_o(q3)
  );

  // ---------------- F1: intensity terms ----------------
  logic f1_vld_q;
  f1_t  f1_d, f1_q;

  always_comb begin
    logic [30:0] ksp;
    ksp      = 31'(ks_q) * 31'(pw);
    f1_d.ok  = q3.ok;
    f1_d.col = q3.col;
    f1_d.i1  = 31'({ka_q, 14'd0}) + (q3.ok ? 31'(kd_q) * 31'(q3.cosd) : 31'd0);
    f1_d.i2  = q3.ok ? ({ksp, 8'd0} - 39'(ksp)) : 39'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vld_q <= 1'b0;
    end else if (en) begin
      f1_vld_q <= vld3;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_q <= f1_d;
    end
  end

  // ---------------- channel sums, saturate, round ----------------
  always_comb begin
    logic [39:0] s;
    s = '0;
    for (int c = 0; c < 3; c++) begin
      s = 40'(f1_q.col[c]) * 40'(f1_q.i1) + 40'(f1_q.i2);
      if (s > {4'd0, 8'hFF, 28'd0}) s = {4'd0, 8'hFF, 28'd0};
      s = s + (40'd1 << 27);
      res_d.col[c] = s[35:28];
    end
    res_d.dgn = !f1_q.ok;
  end

  // ---------------- output word and skid ----------------
  logic pop;
  assign pop = out_vld_q && !stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (pop) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end
    end else if (!out_vld_q || pop) begin
      out_vld_q <= f1_vld_q;
    end else begin
      skid_vld_q <= f1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (pop) out_q <= skid_q;
    end else if (!out_vld_q || pop) begin
      out_q <= res_d;
    end else begin
      skid_q <= res_d;
    end
  end

  assign valid_o      = out_vld_q;
  assign out_red_o    = out_q.col[0];
  assign out_green_o  = out_q.col[1];
  assign out_blue_o   = out_q.col[2];
  assign degenerate_o = out_q.dgn;

`ifndef NO_ASSERTIONS
  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid holds a word while the output register is empty");

  a_skid_fill_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_vld_q) |-> $past(out_vld_q && stall_i))
    else $error("skid filled without a stalled output word");

  a_dark_degenerate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.dgn && (ka_q == 16'd0)) |-> (out_q.col == '0))
    else $error("degenerate vertex with zero ambient is not black");
`endif

endmodule
`default_nettype wire

FILE: sv/pvs_norm.sv
// Pipelined vector normalizer: prescale, sum of squares, bit-serial sqrt, restoring divide.
`default_nettype none
module pvs_norm #(
  parameter int DW = 21
) (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic [2:0][DW-1:0]                  d_i,
  output logic [2:0][pvs_pkg::UNIT_W-1:0]     u_o,
  output logic                                ok_o
);
  import pvs_pkg::*;

  localparam int EW   = (DW > 30) ? DW : 30;
  localparam int SH_W = $clog2(DW + 1);

  nrm_side_t        a_d, a_q, b_q;
  logic [2:0][59:0] sq_q;

  logic [63:0] rem_d  [SQRT_STEPS+1];
  logic [63:0] rem_q  [SQRT_STEPS+1];
  logic [30:0] root_d [SQRT_STEPS+1];
  logic [30:0] root_q [SQRT_STEPS+1];
  nrm_side_t   ss_d   [SQRT_STEPS+1];
  nrm_side_t   ss_q   [SQRT_STEPS+1];

  nrm_div_t    dv_d   [DIV_STEPS+1];
  nrm_div_t    dv_q   [DIV_STEPS+1];

  // magnitudes, then shift until the largest is below 2^30
  always_comb begin
    logic [2:0][DW-1:0] mag;
    logic [DW-1:0]      mx;
    logic [SH_W-1:0]    sh;
    logic [EW-1:0]      ext;
    mx  = '0;
    sh  = '0;
    ext = '0;
    a_d = '0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = d_i[i][DW-1] ? (~d_i[i] + 1'b1) : d_i[i];
      if (mag[i] > mx) mx = mag[i];
    end
    for (int k = 30; k < DW; k++) begin
      if (mx[k]) sh = SH_W'(k - 29);
    end
    for (int i = 0; i < 3; i++) begin
      ext          = EW'(mag[i]) >> sh;
      a_d.sm[i]    = ext[29:0];
      a_d.neg[i]   = d_i[i][DW-1];
    end
    a_d.zero = (mx == '0);
  end

  // floor(sqrt), one root bit per stage
  always_comb begin
    logic [63:0] trial;
    int b;
    trial     = '0;
    b         = 0;
    rem_d[0]  = 64'(sq_q[0]) + 64'(sq_q[1]) + 64'(sq_q[2]);
    root_d[0] = '0;
    ss_d[0]   = b_q;
    for (int k = 0; k < SQRT_STEPS; k++) begin
      b     = SQRT_STEPS - 1 - k;
      trial = (64'(root_q[k]) << (b + 1)) + (64'd1 << (2 * b));
      if (rem_q[k] >= trial) begin
        rem_d[k+1]  = rem_q[k] - trial;
        root_d[k+1] = root_q[k] | (31'd1 << b);
      end else begin
        rem_d[k+1]  = rem_q[k];
        root_d[k+1] = root_q[k];
      end
      ss_d[k+1] = ss_q[k];
    end
  end

  // q = (mag*2^15 + len) / (2*len), one quotient bit per stage
  always_comb begin
    logic [46:0] sub;
    int b;
    sub = '0;
    b   = 0;
    for (int i = 0; i < 3; i++) begin
      dv_d[0].rem[i] = {ss_q[SQRT_STEPS].sm[i], 15'd0} + 47'(root_q[SQRT_STEPS]);
    end
    dv_d[0].q    = '0;
    dv_d[0].den  = {root_q[SQRT_STEPS], 1'b0};
    dv_d[0].neg  = ss_q[SQRT_STEPS].neg;
    dv_d[0].zero = ss_q[SQRT_STEPS].zero;
    for (int k = 0; k < DIV_STEPS; k++) begin
      b         = DIV_STEPS - 1 - k;
      dv_d[k+1] = dv_q[k];
      sub       = 47'(dv_q[k].den) << b;
      for (int i = 0; i < 3; i++) begin
        if (dv_q[k].rem[i] >= sub) begin
          dv_d[k+1].rem[i] = dv_q[k].rem[i] - sub;
          dv_d[k+1].q[i]   = dv_q[k].q[i] | (15'd1 << b);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q <= a_d;
      b_q <= a_q;
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= 60'(a_q.sm[i]) * 60'(a_q.sm[i]);
      end
      for (int k = 0; k <= SQRT_STEPS; k++) begin
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
        ss_q[k]   <= ss_d[k];
      end
      for (int k = 0; k <= DIV_STEPS; k++) begin
        dv_q[k] <= dv_d[k];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv_q[DIV_STEPS].zero) begin
        u_o[i] = '0;
      end else if (dv_q[DIV_STEPS].neg[i]) begin
        u_o[i] = -{1'b0, dv_q[DIV_STEPS].q[i]};
      end else begin
        u_o[i] = {1'b0, dv_q[DIV_STEPS].q[i]};
      end
    end
    ok_o = !dv_q[DIV_STEPS].zero;
  end

endmodule
`default_nettype wire

FILE: sv/pvs_delay.sv
// Stall-aware delay line that carries a valid bit and a sideband word.
`default_nettype none
module pvs_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         vld_i,
  input  logic [W-1:0] d_i,
  output logic         vld_o,
  output logic [W-1:0] d_o
);

  logic [DEPTH-1:0] vld_q;
  logic [W-1:0]     dat_q [DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= (vld_q << 1) | DEPTH'(vld_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dat_q[0] <= d_i;
      for (int k = 1; k < DEPTH; k++) begin
        dat_q[k] <= dat_q[k-1];
      end
    end
  end

  assign vld_o = vld_q[DEPTH-1];
  assign d_o   = dat_q[DEPTH-1];

endmodule
`default_nettype wire

FILE: sv/pvs_pow.sv
// Specular power chain: one rounded multiply per stage, stage k active when k < exponent.
`default_nettype none
module pvs_pow (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [pvs_pkg::COS_W-1:0]   cos_i,
  input  logic [7:0]                  exp_i,
  output logic [pvs_pkg::COS_W-1:0]   pow_o
);
  import pvs_pkg::*;

  logic [COS_W-1:0] p_d [POW_STEPS];
  logic [COS_W-1:0] p_q [POW_STEPS];
  logic [COS_W-1:0] c_d [POW_STEPS];
  logic [COS_W-1:0] c_q [POW_STEPS];

  always_comb begin
    logic [29:0] prod;
    prod   = 30'(UNIT_ONE) * 30'(cos_i) + 30'd8192;
    p_d[0] = (exp_i != 8'd0) ? prod[28:14] : UNIT_ONE;
    c_d[0] = cos_i;
    for (int k = 1; k < POW_STEPS; k++) begin
      prod   = 30'(p_q[k-1]) * 30'(c_q[k-1]) + 30'd8192;
      p_d[k] = (8'(k) < exp_i) ? prod[28:14] : p_q[k-1];
      c_d[k] = c_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < POW_STEPS; k++) begin
        p_q[k] <= p_d[k];
        c_q[k] <= c_d[k];
      end
    end
  end

  assign pow_o = p_q[POW_STEPS-1];

endmodule
`default_nettype wire
